// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: hw/rtl/vebc_pkg.sv
`timescale 1ns / 1ps
package vebc_pkg;
	localparam int FRAC_BITS = 8;
	localparam int CRD_W = 24;
	localparam int AREA_W = 15;
	localparam int MAX_W = AREA_W + FRAC_BITS;
	// Signed width that holds any clip limit with room for a saturation level above it.
	localparam int CW = (MAX_W + 1 > CRD_W + 1) ? MAX_W + 1 : CRD_W + 1;
	localparam int QW = CW + 1;
	localparam int DLT_W = CRD_W + 1;
	localparam int PRD_W = DLT_W + CRD_W;
	localparam int SQ_W = 2 * DLT_W;
	localparam int KW = PRD_W + 4;
	localparam int MW = DLT_W + CW;
	localparam int NW = ((KW > MW + 1) ? KW : MW + 1) + 1;
	localparam int DEN_W = DLT_W + 1;
	localparam int RW = NW + 2;
	localparam int DIV_ST = (CW + 1) / 2;
	localparam int DIV_N = DIV_ST + 1;

	localparam logic [0:0] CFG_AREA_WIDTH = 1'd0;
	localparam logic [0:0] CFG_AREA_HEIGHT = 1'd1;
	localparam logic [AREA_W-1:0] AREA_RST = 15'd1024;

	typedef struct packed {
		logic signed [CRD_W-1:0] site_a_x;
		logic signed [CRD_W-1:0] site_a_y;
		logic signed [CRD_W-1:0] site_b_x;
		logic signed [CRD_W-1:0] site_b_y;
		logic                    left_present;
		logic signed [CRD_W-1:0] left_vertex_x;
		logic signed [CRD_W-1:0] left_vertex_y;
		logic                    right_present;
		logic signed [CRD_W-1:0] right_vertex_x;
		logic signed [CRD_W-1:0] right_vertex_y;
	} item_t;

	typedef struct packed {
		logic                    visible;
		logic signed [CRD_W-1:0] left_clip_x;
		logic signed [CRD_W-1:0] left_clip_y;
		logic signed [CRD_W-1:0] right_clip_x;
		logic signed [CRD_W-1:0] right_clip_y;
	} result_t;

	// Per-edge context that rides along the pipeline and through the dividers.
	typedef struct packed {
		logic signed [KW-1:0]    k2;
		logic signed [DLT_W-1:0] u;
		logic signed [DLT_W-1:0] w;
		logic                    a_one;
		logic                    flip;
		logic                    lp;
		logic                    rp;
		logic                    rej;
		logic signed [CW-1:0]    ga;
		logic signed [CW-1:0]    gb;
		logic signed [QW-1:0]    qa;
		logic signed [QW-1:0]    qb;
		logic                    clamp_a;
		logic                    clamp_b;
		logic                    do_a;
		logic                    do_b;
		logic signed [CW-1:0]    ca;
		logic signed [CW-1:0]    cb;
	} ctx_t;

	function automatic logic signed [CRD_W-1:0] sat_crd(input logic signed [QW-1:0] v);
		logic signed [QW-1:0] hi;
		logic signed [QW-1:0] lo;
		hi = QW'(24'sh7FFFFF);
		lo = QW'(24'sh800000);
		if (v > hi) begin
			return 24'sh7FFFFF;
		end else if (v < lo) begin
			return 24'sh800000;
		end
		return v[CRD_W-1:0];
	endfunction
endpackage

// File: hw/rtl/vebc_div.sv
`timescale 1ns / 1ps
module vebc_div import vebc_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NW-1:0]    num_a,
	input  logic signed [NW-1:0]    num_b,
	input  logic signed [DEN_W-1:0] den,
	input  ctx_t                    ctx_i,
	output logic signed [QW-1:0]    q_a,
	output logic signed [QW-1:0]    q_b,
	output ctx_t                    ctx_o
);
	// Two lanes share one divisor. The quotient is rounded half away from zero
	// by dividing 2|n|+|d| by 2|d|; a top quotient bit set means saturate.
	logic [RW-1:0] ra_s [0:DIV_ST];
	logic [RW-1:0] rb_s [0:DIV_ST];
	logic [RW-1:0] dv_s [0:DIV_ST];
	logic [CW-1:0] qa_s [0:DIV_ST];
	logic [CW-1:0] qb_s [0:DIV_ST];
	logic          ng_a_s [0:DIV_ST];
	logic          ng_b_s [0:DIV_ST];
	ctx_t          cx_s [0:DIV_ST];

	logic [NW-1:0]    na_abs;
	logic [NW-1:0]    nb_abs;
	logic [DEN_W-1:0] d_abs;

	always_comb begin
		na_abs = (num_a < 0) ? NW'(-num_a) : NW'(num_a);
		nb_abs = (num_b < 0) ? NW'(-num_b) : NW'(num_b);
		d_abs  = (den < 0) ? DEN_W'(-den) : DEN_W'(den);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ra_s[0]   <= (RW'(na_abs) << 1) + RW'(d_abs);
			rb_s[0]   <= (RW'(nb_abs) << 1) + RW'(d_abs);
			dv_s[0]   <= RW'(d_abs) << 1;
			qa_s[0]   <= '0;
			qb_s[0]   <= '0;
			ng_a_s[0] <= (num_a < 0) != (den < 0);
			ng_b_s[0] <= (num_b < 0) != (den < 0);
			cx_s[0]   <= ctx_i;
		end
	end

	for (genvar k = 1; k <= DIV_ST; k++) begin : g_step
		logic [RW-1:0] ra_n;
		logic [RW-1:0] rb_n;
		logic [CW-1:0] qa_n;
		logic [CW-1:0] qb_n;

		always_comb begin
			int s;
			int b;
			ra_n = ra_s[k-1];
			rb_n = rb_s[k-1];
			qa_n = qa_s[k-1];
			qb_n = qb_s[k-1];
			for (int t = 0; t < 2; t++) begin
				s = 2 * (k - 1) + t;
				b = CW - 1 - s;
				if (s < CW) begin
					if (ra_n >= (dv_s[k-1] << b)) begin
						ra_n = ra_n - (dv_s[k-1] << b);
						qa_n = qa_n | (CW'(1) << b);
					end
					if (rb_n >= (dv_s[k-1] << b)) begin
						rb_n = rb_n - (dv_s[k-1] << b);
						qb_n = qb_n | (CW'(1) << b);
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ra_s[k]   <= ra_n;
				rb_s[k]   <= rb_n;
				dv_s[k]   <= dv_s[k-1];
				qa_s[k]   <= qa_n;
				qb_s[k]   <= qb_n;
				ng_a_s[k] <= ng_a_s[k-1];
				ng_b_s[k] <= ng_b_s[k-1];
				cx_s[k]   <= cx_s[k-1];
			end
		end
	end

	logic [CW-1:0] mag_a;
	logic [CW-1:0] mag_b;

	always_comb begin
		mag_a = qa_s[DIV_ST][CW-1] ? (CW'(1) << (CW - 1)) : qa_s[DIV_ST];
		mag_b = qb_s[DIV_ST][CW-1] ? (CW'(1) << (CW - 1)) : qb_s[DIV_ST];
		q_a = ng_a_s[DIV_ST] ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
		q_b = ng_b_s[DIV_ST] ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
		ctx_o = cx_s[DIV_ST];
	end
endmodule

// File: hw/rtl/voronoi_edge_bisect_and_clip.sv
`timescale 1ns / 1ps
// Most of the delay from an accepted item to its result beat lies in the two
// long-division pipelines. Throughput: one beat per cycle while the skid is empty;
// a two-entry output register and skid keep input flowing while one result waits.
// Reset clears all valid bits and sets both area registers to 1024 units; datapath
// registers are not reset.
`include "assert_macros.svh"
module voronoi_edge_bisect_and_clip import vebc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [0:0]        cfg_index,
	input  logic [AREA_W-1:0] cfg_data,
	input  logic              item_valid,
	output logic              item_stall,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_stall,
	output result_t           result
);
	localparam int NST = 9 + 2 * DIV_N;

	logic [AREA_W-1:0] area_width_q;
	logic [AREA_W-1:0] area_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			area_width_q  <= AREA_RST;
			area_height_q <= AREA_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_AREA_WIDTH: area_width_q <= cfg_data;
				CFG_AREA_HEIGHT: area_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic signed [CW-1:0] lim_x;
	logic signed [CW-1:0] lim_y;
	assign lim_x = CW'({area_width_q, {FRAC_BITS{1'b0}}});
	assign lim_y = CW'({area_height_q, {FRAC_BITS{1'b0}}});

	logic            en;
	logic            accept;
	logic [NST-1:0]  vld_s;
	logic            out_vld_q;
	logic            skid_full_q;
	result_t         out_q;
	result_t         skid_q;

	// The whole pipeline moves together; it only halts once the skid holds a beat.
	assign en = !skid_full_q;
	assign accept = item_valid && !skid_full_q;
	assign item_stall = skid_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-2:0], accept};
		end
	end

	// Stage 1: capture.
	item_t it_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= item;
		end
	end

	// Stage 2: site differences.
	item_t                   it_s2;
	logic signed [DLT_W-1:0] dx_s2;
	logic signed [DLT_W-1:0] dy_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			it_s2 <= it_s1;
			dx_s2 <= DLT_W'(it_s1.site_b_x) - DLT_W'(it_s1.site_a_x);
			dy_s2 <= DLT_W'(it_s1.site_b_y) - DLT_W'(it_s1.site_a_y);
		end
	end

	// Stage 3: slope class, vertex order and the start points on the walking axis.
	ctx_t cx_n3;
	always_comb begin
		logic [DLT_W-1:0]     adx;
		logic [DLT_W-1:0]     ady;
		logic                 a_one;
		logic                 flip;
		logic                 vap;
		logic                 vbp;
		logic signed [CW-1:0] vca;
		logic signed [CW-1:0] vcb;
		logic signed [CW-1:0] lim1;
		adx = (dx_s2 < 0) ? DLT_W'(-dx_s2) : DLT_W'(dx_s2);
		ady = (dy_s2 < 0) ? DLT_W'(-dy_s2) : DLT_W'(dy_s2);
		a_one = (adx > ady) || (dx_s2 == dy_s2);
		flip = a_one && ((dy_s2 == 0) || ((dx_s2 > 0) == (dy_s2 > 0)));
		vap = flip ? it_s2.right_present : it_s2.left_present;
		vbp = flip ? it_s2.left_present : it_s2.right_present;
		if (a_one) begin
			vca = flip ? CW'(it_s2.right_vertex_y) : CW'(it_s2.left_vertex_y);
			vcb = flip ? CW'(it_s2.left_vertex_y) : CW'(it_s2.right_vertex_y);
			lim1 = lim_y;
		end else begin
			vca = flip ? CW'(it_s2.right_vertex_x) : CW'(it_s2.left_vertex_x);
			vcb = flip ? CW'(it_s2.left_vertex_x) : CW'(it_s2.right_vertex_x);
			lim1 = lim_x;
		end
		cx_n3 = '0;
		cx_n3.a_one = a_one;
		cx_n3.flip = flip;
		cx_n3.lp = it_s2.left_present;
		cx_n3.rp = it_s2.right_present;
		cx_n3.u = a_one ? dy_s2 : dx_s2;
		cx_n3.w = a_one ? dx_s2 : dy_s2;
		cx_n3.ga = (vap && vca > 0) ? vca : '0;
		cx_n3.gb = (vbp && vcb < lim1) ? vcb : lim1;
		cx_n3.rej = ((dx_s2 == 0) && (dy_s2 == 0)) || (cx_n3.ga > lim1) || (cx_n3.gb < 0);
	end

	ctx_t                    cx_s3;
	logic signed [CRD_W-1:0] ax_s3;
	logic signed [CRD_W-1:0] ay_s3;
	logic signed [DLT_W-1:0] dx_s3;
	logic signed [DLT_W-1:0] dy_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3 <= cx_n3;
			ax_s3 <= it_s2.site_a_x;
			ay_s3 <= it_s2.site_a_y;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
		end
	end

	// Stage 4: products for the doubled line constant and the first numerators.
	ctx_t                    cx_s4;
	logic signed [PRD_W-1:0] pax_s4;
	logic signed [PRD_W-1:0] pay_s4;
	logic signed [SQ_W-1:0]  pxx_s4;
	logic signed [SQ_W-1:0]  pyy_s4;
	logic signed [MW-1:0]    ma_s4;
	logic signed [MW-1:0]    mb_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s4  <= cx_s3;
			pax_s4 <= PRD_W'(ax_s3) * PRD_W'(dx_s3);
			pay_s4 <= PRD_W'(ay_s3) * PRD_W'(dy_s3);
			pxx_s4 <= SQ_W'(dx_s3) * SQ_W'(dx_s3);
			pyy_s4 <= SQ_W'(dy_s3) * SQ_W'(dy_s3);
			ma_s4  <= MW'(cx_s3.u) * MW'(cx_s3.ga);
			mb_s4  <= MW'(cx_s3.u) * MW'(cx_s3.gb);
		end
	end

	// Stage 5: 2K = 2*(ax*dx + ay*dy) + dx*dx + dy*dy, exact.
	ctx_t cx_n5;
	always_comb begin
		cx_n5 = cx_s4;
		cx_n5.k2 = ((KW'(pax_s4) + KW'(pay_s4)) <<< 1) + KW'(pxx_s4) + KW'(pyy_s4);
	end

	ctx_t                 cx_s5;
	logic signed [MW-1:0] ma_s5;
	logic signed [MW-1:0] mb_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s5 <= cx_n5;
			ma_s5 <= ma_s4;
			mb_s5 <= mb_s4;
		end
	end

	// Stage 6: numerators and divisor for the first point on each end.
	ctx_t                    cx_s6;
	logic signed [NW-1:0]    na_s6;
	logic signed [NW-1:0]    nb_s6;
	logic signed [DEN_W-1:0] den_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s6  <= cx_s5;
			na_s6  <= NW'(cx_s5.k2) - (NW'(ma_s5) <<< 1);
			nb_s6  <= NW'(cx_s5.k2) - (NW'(mb_s5) <<< 1);
			den_s6 <= DEN_W'(cx_s5.w) <<< 1;
		end
	end

	logic signed [QW-1:0] q1a;
	logic signed [QW-1:0] q1b;
	ctx_t                 cx_d1;

	vebc_div u_div1 (
		.clk   (clk),
		.en    (en),
		.num_a (na_s6),
		.num_b (nb_s6),
		.den   (den_s6),
		.ctx_i (cx_s6),
		.q_a   (q1a),
		.q_b   (q1b),
		.ctx_o (cx_d1)
	);

	// Stage 7: clip on the other axis; a clamped end needs its walking coordinate again.
	ctx_t cx_n7;
	always_comb begin
		logic signed [CW-1:0] lim2;
		logic                 hi_a;
		logic                 lo_a;
		logic                 hi_b;
		logic                 lo_b;
		lim2 = cx_d1.a_one ? lim_x : lim_y;
		hi_a = q1a > QW'(lim2);
		lo_a = q1a < 0;
		hi_b = q1b > QW'(lim2);
		lo_b = q1b < 0;
		cx_n7 = cx_d1;
		cx_n7.qa = q1a;
		cx_n7.qb = q1b;
		cx_n7.rej = cx_d1.rej || (hi_a && hi_b) || (lo_a && lo_b);
		cx_n7.clamp_a = hi_a || lo_a;
		cx_n7.clamp_b = hi_b || lo_b;
		cx_n7.ca = hi_a ? lim2 : '0;
		cx_n7.cb = hi_b ? lim2 : '0;
		cx_n7.do_a = (hi_a || lo_a) && (cx_d1.u != 0);
		cx_n7.do_b = (hi_b || lo_b) && (cx_d1.u != 0);
	end

	ctx_t cx_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s7 <= cx_n7;
		end
	end

	// Stage 8: products for the second division.
	ctx_t                 cx_s8;
	logic signed [MW-1:0] p2a_s8;
	logic signed [MW-1:0] p2b_s8;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s8  <= cx_s7;
			p2a_s8 <= MW'(cx_s7.w) * MW'(cx_s7.ca);
			p2b_s8 <= MW'(cx_s7.w) * MW'(cx_s7.cb);
		end
	end

	// Stage 9: numerators and divisor for the clamped ends.
	ctx_t                    cx_s9;
	logic signed [NW-1:0]    n2a_s9;
	logic signed [NW-1:0]    n2b_s9;
	logic signed [DEN_W-1:0] den2_s9;
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s9   <= cx_s8;
			n2a_s9  <= NW'(cx_s8.k2) - (NW'(p2a_s8) <<< 1);
			n2b_s9  <= NW'(cx_s8.k2) - (NW'(p2b_s8) <<< 1);
			den2_s9 <= DEN_W'(cx_s8.u) <<< 1;
		end
	end

	logic signed [QW-1:0] q2a;
	logic signed [QW-1:0] q2b;
	ctx_t                 cx_d2;

	vebc_div u_div2 (
		.clk   (clk),
		.en    (en),
		.num_a (n2a_s9),
		.num_b (n2b_s9),
		.den   (den2_s9),
		.ctx_i (cx_s9),
		.q_a   (q2a),
		.q_b   (q2b),
		.ctx_o (cx_d2)
	);

	// Assemble both endpoints and put them in left/right order.
	result_t res;
	always_comb begin
		logic signed [QW-1:0] oa;
		logic signed [QW-1:0] ob;
		logic signed [QW-1:0] wa;
		logic signed [QW-1:0] wb;
		logic signed [QW-1:0] xa;
		logic signed [QW-1:0] ya;
		logic signed [QW-1:0] xb;
		logic signed [QW-1:0] yb;
		logic                 left_first;
		oa = cx_d2.clamp_a ? QW'(cx_d2.ca) : cx_d2.qa;
		ob = cx_d2.clamp_b ? QW'(cx_d2.cb) : cx_d2.qb;
		wa = cx_d2.do_a ? q2a : QW'(cx_d2.ga);
		wb = cx_d2.do_b ? q2b : QW'(cx_d2.gb);
		xa = cx_d2.a_one ? oa : wa;
		ya = cx_d2.a_one ? wa : oa;
		xb = cx_d2.a_one ? ob : wb;
		yb = cx_d2.a_one ? wb : ob;
		left_first = !cx_d2.flip || (!cx_d2.lp && !cx_d2.rp);
		res = '0;
		if (!cx_d2.rej) begin
			res.visible = 1'b1;
			if (left_first) begin
				res.left_clip_x  = sat_crd(xa);
				res.left_clip_y  = sat_crd(ya);
				res.right_clip_x = sat_crd(xb);
				res.right_clip_y = sat_crd(yb);
			end else begin
				res.left_clip_x  = sat_crd(xb);
				res.left_clip_y  = sat_crd(yb);
				res.right_clip_x = sat_crd(xa);
				res.right_clip_y = sat_crd(ya);
			end
		end
	end

	// Output register with a one-beat skid behind it.
	logic take;
	logic inc;
	assign take = out_vld_q && !result_stall;
	assign inc = vld_s[NST-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			out_vld_q   <= skid_full_q || inc;
			skid_full_q <= 1'b0;
		end else if (inc) begin
			skid_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_full_q ? skid_q : res;
		end else if (inc) begin
			skid_q <= res;
		end
	end

	assign result_valid = out_vld_q;
	assign result = out_q;

	`AST_IMP(a_skid_needs_out, skid_full_q, out_vld_q, "skid holds a beat with output empty")
	`AST_NXT(a_accept_enters, item_valid && !item_stall, vld_s[0], "accepted beat lost at entry")
	`AST_IMP(a_hidden_zero, out_vld_q && !out_q.visible, (out_q.left_clip_x == '0) && (out_q.left_clip_y == '0) && (out_q.right_clip_x == '0) && (out_q.right_clip_y == '0), "hidden edge carries coordinates")
	`AST_IMP(a_skid_cause, $rose(skid_full_q), $past(out_vld_q && result_stall), "skid filled without a stalled output")
endmodule

// File: tb/voronoi_edge_bisect_and_clip_checker.sv
`timescale 1ns / 1ps
module voronoi_edge_bisect_and_clip_checker import vebc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [0:0]        cfg_index,
	input  logic [AREA_W-1:0] cfg_data,
	input  logic              item_valid,
	input  logic              item_stall,
	input  item_t             item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  result_t           result,
	output int                failures,
	output int                outstanding
);
	longint clip_w;
	longint clip_h;
	result_t edge_q[$];

	function automatic longint div_nearest(input longint num, input longint den);
		longint n;
		longint d;
		longint q;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = (2 * n + d) / (2 * d);
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic logic [CRD_W-1:0] sat24(input longint v);
		if (v > 64'sd8388607) begin
			return 24'h7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'h800000;
		end
		return v[CRD_W-1:0];
	endfunction

	// Clipped bisector of the two sites; every coordinate solved on the line is one rounded division.
	function automatic result_t bisect_clip(input item_t it, input longint w, input longint h);
		result_t r;
		longint ax, ay, bx, by, lx, ly, rx, ry;
		longint dx, dy, k2, adx, ady, maxx, maxy;
		longint pax, pay, pbx, pby, vax, vay, vbx, vby;
		logic lp, rp, a_one, flip, vap, vbp;
		r = '0;
		ax = longint'(it.site_a_x); ay = longint'(it.site_a_y);
		bx = longint'(it.site_b_x); by = longint'(it.site_b_y);
		lx = longint'(it.left_vertex_x); ly = longint'(it.left_vertex_y);
		rx = longint'(it.right_vertex_x); ry = longint'(it.right_vertex_y);
		lp = it.left_present; rp = it.right_present;
		maxx = w <<< FRAC_BITS;
		maxy = h <<< FRAC_BITS;
		dx = bx - ax;
		dy = by - ay;
		if (dx == 0 && dy == 0) begin
			return r;
		end
		k2 = 2 * (ax * dx + ay * dy) + dx * dx + dy * dy;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		a_one = adx > ady || dx == dy;
		flip = a_one && (dy == 0 || ((dx > 0) == (dy > 0)));
		vap = flip ? rp : lp; vax = flip ? rx : lx; vay = flip ? ry : ly;
		vbp = flip ? lp : rp; vbx = flip ? lx : rx; vby = flip ? ly : ry;
		if (a_one) begin
			pay = (vap && vay > 0) ? vay : 0;
			if (pay > maxy) begin
				return r;
			end
			pax = div_nearest(k2 - 2 * dy * pay, 2 * dx);
			pby = (vbp && vby < maxy) ? vby : maxy;
			if (pby < 0) begin
				return r;
			end
			pbx = div_nearest(k2 - 2 * dy * pby, 2 * dx);
			if ((pax > maxx && pbx > maxx) || (pax < 0 && pbx < 0)) begin
				return r;
			end
			if (pax > maxx || pax < 0) begin
				pax = pax > maxx ? maxx : 0;
				if (dy != 0) begin
					pay = div_nearest(k2 - 2 * dx * pax, 2 * dy);
				end
			end
			if (pbx > maxx || pbx < 0) begin
				pbx = pbx > maxx ? maxx : 0;
				if (dy != 0) begin
					pby = div_nearest(k2 - 2 * dx * pbx, 2 * dy);
				end
			end
		end else begin
			pax = (vap && vax > 0) ? vax : 0;
			if (pax > maxx) begin
				return r;
			end
			pay = div_nearest(k2 - 2 * dx * pax, 2 * dy);
			pbx = (vbp && vbx < maxx) ? vbx : maxx;
			if (pbx < 0) begin
				return r;
			end
			pby = div_nearest(k2 - 2 * dx * pbx, 2 * dy);
			if ((pay > maxy && pby > maxy) || (pay < 0 && pby < 0)) begin
				return r;
			end
			if (pay > maxy || pay < 0) begin
				pay = pay > maxy ? maxy : 0;
				if (dx != 0) begin
					pax = div_nearest(k2 - 2 * dy * pay, 2 * dx);
				end
			end
			if (pby > maxy || pby < 0) begin
				pby = pby > maxy ? maxy : 0;
				if (dx != 0) begin
					pbx = div_nearest(k2 - 2 * dy * pby, 2 * dx);
				end
			end
		end
		r.visible = 1'b1;
		if (!flip || (!lp && !rp)) begin
			r.left_clip_x = sat24(pax); r.left_clip_y = sat24(pay);
			r.right_clip_x = sat24(pbx); r.right_clip_y = sat24(pby);
		end else begin
			r.left_clip_x = sat24(pbx); r.left_clip_y = sat24(pby);
			r.right_clip_x = sat24(pax); r.right_clip_y = sat24(pay);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		result_t want;
		int pushed;
		int popped;
		if (!arst_n) begin
			clip_w <= 1024;
			clip_h <= 1024;
			failures <= 0;
			outstanding <= 0;
			edge_q.delete();
		end else begin
			pushed = 0;
			popped = 0;
			if (cfg_write) begin
				if (cfg_index == CFG_AREA_WIDTH) begin
					clip_w <= longint'(cfg_data);
				end else if (cfg_index == CFG_AREA_HEIGHT) begin
					clip_h <= longint'(cfg_data);
				end
			end
			if (item_valid && !item_stall) begin
				edge_q.push_back(bisect_clip(item, clip_w, clip_h));
				pushed = 1;
			end
			if (result_valid && !result_stall) begin
				if (edge_q.size() == pushed) begin
					$display("%0t: result beat with nothing expected, got %h", $time, result);
					failures <= failures + 1;
				end else begin
					want = edge_q.pop_front();
					popped = 1;
					if (want.visible !== result.visible ||
					    want.left_clip_x !== result.left_clip_x ||
					    want.left_clip_y !== result.left_clip_y ||
					    want.right_clip_x !== result.right_clip_x ||
					    want.right_clip_y !== result.right_clip_y) begin
						$display("%0t: mismatch, expected vis %b L(%h,%h) R(%h,%h), got vis %b L(%h,%h) R(%h,%h)",
							$time, want.visible, want.left_clip_x, want.left_clip_y,
							want.right_clip_x, want.right_clip_y, result.visible,
							result.left_clip_x, result.left_clip_y,
							result.right_clip_x, result.right_clip_y);
						failures <= failures + 1;
					end
				end
			end
			outstanding <= outstanding + pushed - popped;
		end
	end
endmodule

// File: tb/voronoi_edge_bisect_and_clip_test.sv
`timescale 1ns / 1ps
module voronoi_edge_bisect_and_clip_test;
	import vebc_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_write = 1'b0;
	logic [0:0]        cfg_index = CFG_AREA_WIDTH;
	logic [AREA_W-1:0] cfg_data = '0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	item_t             item = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	result_t           result;
	int                failures;
	int                outstanding;
	int                burst_mode = 0;
	longint            span;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	voronoi_edge_bisect_and_clip dut (.*);

	voronoi_edge_bisect_and_clip_checker chk (.*);

	function automatic int draw_gap();
		if (burst_mode != 0) begin
			return 0;
		end
		return $urandom_range(0, 9);
	endfunction

	task automatic send_edge(input item_t x);
		int gap;
		logic st;
		gap = draw_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= x;
		do begin
			@(negedge clk);
			st = item_stall;
			@(posedge clk);
		end while (st);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_area(input logic [AREA_W-1:0] w, input logic [AREA_W-1:0] h);
		cfg_write <= 1'b1;
		cfg_index <= CFG_AREA_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= CFG_AREA_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		span = (w > h ? w : h) * 256;
		if (span < 256) begin
			span = 256;
		end
	endtask

	function automatic item_t mk(input int ax, ay, bx, by, input int lp, input int lx, ly,
			input int rp, input int rx, ry);
		item_t x;
		x.site_a_x = CRD_W'(ax); x.site_a_y = CRD_W'(ay);
		x.site_b_x = CRD_W'(bx); x.site_b_y = CRD_W'(by);
		x.left_present = lp[0];
		x.left_vertex_x = CRD_W'(lx); x.left_vertex_y = CRD_W'(ly);
		x.right_present = rp[0];
		x.right_vertex_x = CRD_W'(rx); x.right_vertex_y = CRD_W'(ry);
		return x;
	endfunction

	// Mostly coordinates near the area so that edges reach the clipping; some full range.
	function automatic logic [CRD_W-1:0] coord();
		longint v;
		if ($urandom_range(0, 9) < 7) begin
			v = longint'($urandom_range(0, 32'(3 * span))) - span;
			if (v > 8388607) v = 8388607;
			if (v < -8388608) v = -8388608;
			return v[CRD_W-1:0];
		end
		return CRD_W'($urandom());
	endfunction

	function automatic item_t rand_edge();
		item_t x;
		int d;
		x.site_a_x = coord(); x.site_a_y = coord();
		x.site_b_x = coord(); x.site_b_y = coord();
		x.left_present = 1'($urandom_range(0, 1));
		x.left_vertex_x = coord(); x.left_vertex_y = coord();
		x.right_present = 1'($urandom_range(0, 1));
		x.right_vertex_x = coord(); x.right_vertex_y = coord();
		d = $urandom_range(1, 4096);
		case ($urandom_range(0, 15))
			0: x.site_b_y = x.site_a_y;
			1: x.site_b_x = x.site_a_x;
			2: begin
				x.site_b_x = CRD_W'(x.site_a_x + d);
				x.site_b_y = CRD_W'(x.site_a_y + d);
			end
			3: begin
				x.site_b_x = CRD_W'(x.site_a_x + d);
				x.site_b_y = CRD_W'(x.site_a_y - d);
			end
			4: x.site_b_x = x.site_a_x;
			default: ;
		endcase
		if (x.site_b_x == x.site_a_x && $urandom_range(0, 1) == 0) begin
			x.site_b_y = x.site_a_y;
		end
		return x;
	endfunction

	initial begin
		timeout_guard: begin
			#50ms;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			logic got;
			gap = draw_gap();
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do begin
				@(negedge clk);
				got = result_valid;
				@(posedge clk);
			end while (!got);
		end
	end

	initial begin
		logic [AREA_W-1:0] ws[5];
		logic [AREA_W-1:0] hs[5];
		span = 1024 * 256;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked edges under the reset area.
		send_edge(mk(1000, 1000, 1000, 1000, 1, 5, 5, 1, 9, 9));
		send_edge(mk(0, 100000, 200000, 100000, 0, 0, 0, 0, 0, 0));
		send_edge(mk(100000, 0, 100000, 200000, 0, 0, 0, 0, 0, 0));
		send_edge(mk(0, 0, 5000, 5000, 1, 1000, 50000, 1, 60000, 2000));
		send_edge(mk(0, 200000, 5000, 195000, 1, 2000, 3000, 1, 90000, 95000));
		send_edge(mk(10000, 20000, 90000, 30000, 1, 0, 70000, 1, 0, 1000));
		send_edge(mk(20000, 10000, 30000, 90000, 1, 100000, 0, 1, 5000, 0));
		send_edge(mk(20000, 10000, 30000, -90000, 1, 5000, 0, 0, 0, 0));
		send_edge(mk(20000, 10000, 30000, -90000, 0, 0, 0, 1, 5000, 0));
		send_edge(mk(-8388608, -8388608, 8388607, 8388607, 0, 0, 0, 0, 0, 0));
		send_edge(mk(8388607, -8388608, -8388608, 8388607, 1, -8388608, 8388607,
			1, 8388607, -8388608));
		send_edge(mk(-8388608, 0, -8388000, 0, 0, 0, 0, 0, 0, 0));
		send_edge(mk(0, -8388608, 0, -8388000, 0, 0, 0, 0, 0, 0));
		send_edge(mk(0, 0, 600000, 0, 1, 0, 300000, 1, 0, 10));
		send_edge(mk(0, 0, 0, 600000, 1, 300000, 0, 1, 20, 0));
		send_edge(mk(0, 0, 3, 1, 0, 0, 0, 0, 0, 0));
		send_edge(mk(1, 2, 4, 9, 1, -5, -5, 1, 400000, 400000));
		send_edge(mk(50000, 50000, 60000, 52000, 1, 0, -10, 1, 0, -20));

		ws = '{15'd1024, 15'd1, 15'd32767, 15'd0, 15'd1};
		hs = '{15'd777, 15'd1, 15'd32767, 15'd5, 15'd32767};
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			if (ph < 5) begin
				set_area(ws[ph], hs[ph]);
			end else begin
				set_area(AREA_W'($urandom_range(1, 32767)), AREA_W'($urandom_range(1, 32767)));
			end
			for (int i = 0; i < 215; i++) begin
				if (i % 60 == 0) begin
					burst_mode = ($urandom_range(0, 2) == 0);
				end
				send_edge(rand_edge());
			end
			burst_mode = 0;
		end
		drain();

		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/vebc_pkg.sv
hw/rtl/vebc_div.sv
hw/rtl/voronoi_edge_bisect_and_clip.sv
tb/voronoi_edge_bisect_and_clip_checker.sv
tb/voronoi_edge_bisect_and_clip_test.sv
